[sv/ppmhp_pkg.sv]
package ppmhp_pkg;

    // Default sizing of the number accumulator and digit counter
    localparam int MAX_DIGITS_DEF = 31;
    localparam int VALUE_BITS_DEF = 16;

    // Width of the reported image dimensions
    localparam int DIM_W = 16;

    // Header bytes of interest
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_HASH  = 8'h23;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;
    localparam logic [7:0] BYTE_SIX   = 8'h36;
    localparam logic [7:0] BYTE_P     = 8'h50;

    // Nominal maximum color value; anything else raises the warning
    localparam int MAXVAL_NOMINAL = 255;

    // Parser phase
    typedef enum logic [2:0] {
        PH_TOP     = 3'd0,
        PH_COMMENT = 3'd1,
        PH_MAGIC   = 3'd2,
        PH_WIDTH   = 3'd3,
        PH_HEIGHT  = 3'd4,
        PH_MAXVAL  = 3'd5
    } t_phase;

    // Reported status
    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_DONE      = 3'd1,
        ST_BADMAGIC  = 3'd2,
        ST_BADFORMAT = 3'd3,
        ST_EARLYEND  = 3'd4
    } t_status;

    // One result item
    typedef struct packed {
        logic             warning;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
        t_status          status;
    } t_result;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= BYTE_ZERO) && (b <= BYTE_NINE);
    endfunction

    // Skipped at top level: space, tab, CR, LF
    function automatic logic is_top_space(input logic [7:0] b);
        return (b == BYTE_SPACE) || (b == BYTE_TAB) || (b == BYTE_LF) || (b == BYTE_CR);
    endfunction

    // Ends a number: tab through CR, or space
    function automatic logic is_num_end(input logic [7:0] b);
        return (b == BYTE_SPACE) || ((b >= BYTE_TAB) && (b <= BYTE_CR));
    endfunction

endpackage

[sv/ppmhp_parse.sv]
module ppmhp_parse #(
    parameter int MAX_DIGITS = ppmhp_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = ppmhp_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_eoi,
    input  logic               i_restart,
    output ppmhp_pkg::t_result o_result
);
    import ppmhp_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    // Parser state
    t_phase                r_phase;
    t_status               r_code;
    logic [VALUE_BITS-1:0] r_acc;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIM_W-1:0]      r_width;
    logic [DIM_W-1:0]      r_height;
    logic                  r_warn;

    t_phase                n_phase;
    t_status               n_code;
    logic [VALUE_BITS-1:0] n_acc;
    logic [CNT_W-1:0]      n_cnt;
    logic [DIM_W-1:0]      n_width;
    logic [DIM_W-1:0]      n_height;
    logic                  n_warn;

    // State as seen by this transaction (restart wipes it first)
    t_phase                c_phase;
    t_status               c_code;
    logic [VALUE_BITS-1:0] c_acc;
    logic [CNT_W-1:0]      c_cnt;
    logic [DIM_W-1:0]      c_width;
    logic [DIM_W-1:0]      c_height;
    logic                  c_warn;

    logic                   w_work;
    logic [VALUE_BITS-1:0]  w_base;
    logic [VALUE_BITS+3:0]  w_base_ext;
    logic [VALUE_BITS+3:0]  w_prod;
    logic [VALUE_BITS-1:0]  w_sat;
    logic [VALUE_BITS+15:0] w_acc_ext;
    logic                   w_room;

    assign c_phase  = i_restart ? PH_TOP  : r_phase;
    assign c_code   = i_restart ? ST_BUSY : r_code;
    assign c_acc    = i_restart ? '0 : r_acc;
    assign c_cnt    = i_restart ? '0 : r_cnt;
    assign c_width  = i_restart ? '0 : r_width;
    assign c_height = i_restart ? '0 : r_height;
    assign c_warn   = i_restart ? 1'b0 : r_warn;

    // A byte is parsed only while busy and not at end of input
    assign w_work = (c_code == ST_BUSY) && !i_eoi;

    // Decimal accumulate: acc*10 + digit, saturating at all ones
    assign w_base     = (c_phase == PH_TOP) ? '0 : c_acc;
    assign w_base_ext = {4'd0, w_base};
    assign w_prod     = (w_base_ext << 3) + (w_base_ext << 1)
                      + {{VALUE_BITS{1'b0}}, i_byte[3:0]};  // low nibble of '0'..'9'
    assign w_sat      = (w_prod > {4'd0, {VALUE_BITS{1'b1}}}) ? {VALUE_BITS{1'b1}}
                                                             : w_prod[VALUE_BITS-1:0];
    assign w_acc_ext  = {{DIM_W{1'b0}}, c_acc};
    assign w_room     = c_cnt < CNT_W'(MAX_DIGITS);

    // Next phase
    always_comb begin
        n_phase = c_phase;
        if (w_work) begin
            unique case (c_phase)
                PH_TOP: begin
                    if (i_byte == BYTE_HASH) begin
                        n_phase = PH_COMMENT;
                    end else if (i_byte == BYTE_P) begin
                        n_phase = PH_MAGIC;
                    end else if (is_digit(i_byte)) begin
                        n_phase = PH_WIDTH;
                    end
                end
                PH_COMMENT: begin
                    if (i_byte == BYTE_LF || i_byte == BYTE_CR) begin
                        n_phase = PH_TOP;
                    end
                end
                PH_MAGIC: begin
                    if (i_byte == BYTE_SIX) begin
                        n_phase = PH_TOP;
                    end
                end
                PH_WIDTH: begin
                    if (!is_digit(i_byte) && is_num_end(i_byte)) begin
                        n_phase = PH_HEIGHT;
                    end
                end
                PH_HEIGHT: begin
                    if (!is_digit(i_byte) && is_num_end(i_byte)) begin
                        n_phase = PH_MAXVAL;
                    end
                end
                PH_MAXVAL: begin
                    if (!is_digit(i_byte) && is_num_end(i_byte)) begin
                        n_phase = PH_TOP;
                    end
                end
                default: begin
                    n_phase = c_phase;
                end
            endcase
        end
    end

    // Status, accumulator and captured values
    always_comb begin
        n_code   = c_code;
        n_acc    = c_acc;
        n_cnt    = c_cnt;
        n_width  = c_width;
        n_height = c_height;
        n_warn   = c_warn;
        if (c_code == ST_BUSY && i_eoi) begin
            n_code = ST_EARLYEND;
        end else if (w_work) begin
            unique case (c_phase)
                PH_TOP: begin
                    if (is_digit(i_byte)) begin
                        n_acc = w_sat;
                        n_cnt = CNT_W'(1);
                    end else if (!is_top_space(i_byte) && i_byte != BYTE_HASH
                                 && i_byte != BYTE_P) begin
                        n_code = ST_BADFORMAT;
                    end
                end
                PH_COMMENT: begin
                    n_code = c_code;
                end
                PH_MAGIC: begin
                    if (i_byte != BYTE_SIX) begin
                        n_code = ST_BADMAGIC;
                    end
                end
                PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                    if (is_digit(i_byte)) begin
                        if (w_room) begin
                            n_acc = w_sat;
                            n_cnt = c_cnt + CNT_W'(1);
                        end else begin
                            n_code = ST_BADFORMAT;
                        end
                    end else if (is_num_end(i_byte)) begin
                        // number complete: capture it (width, height) or check it (maxval), and clear the accumulator
                        n_acc = '0;
                        n_cnt = '0;
                        if (c_phase == PH_WIDTH) begin
                            n_width = w_acc_ext[DIM_W-1:0];
                        end else if (c_phase == PH_HEIGHT) begin
                            n_height = w_acc_ext[DIM_W-1:0];
                        end else begin
                            if (c_acc != VALUE_BITS'(MAXVAL_NOMINAL)) begin
                                n_warn = 1'b1;
                            end
                            n_code = ST_DONE;
                        end
                    end else begin
                        n_code = ST_BADFORMAT;
                    end
                end
                default: begin
                    n_code = c_code;
                end
            endcase
        end
    end

    // State update per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TOP;
            r_code   <= ST_BUSY;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_warn   <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_code   <= n_code;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_width  <= n_width;
            r_height <= n_height;
            r_warn   <= n_warn;
        end
    end

    assign o_result.status  = n_code;
    assign o_result.width   = n_width;
    assign o_result.height  = n_height;
    assign o_result.warning = n_warn;

endmodule

[sv/ppm_header_parser.sv]
// Binary PPM header parser, one header byte per input transaction.
// The result for a byte is registered and appears on the master side in the cycle after acceptance.
// Throughput: one byte per cycle; a byte is taken whenever the output register is empty
// or its result is taken in the same cycle, so a stalled result holds off input.
// Reset: synchronous, active low; clears parser state and empties the output register.
module ppm_header_parser #(
    parameter int MAX_DIGITS = ppmhp_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = ppmhp_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_input
    input  logic        s_axis_tuser,   // restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [2:0] status, [18:3] image_width,
                                        // [34:19] image_height, [35] depth_warning
);
    import ppmhp_pkg::*;

    logic    w_step;
    t_result w_result;
    logic    r_out_valid;
    t_result r_out;

    // Take a byte whenever the output register is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_step        = s_axis_tvalid && s_axis_tready;

    ppmhp_parse #(
        .MAX_DIGITS(MAX_DIGITS),
        .VALUE_BITS(VALUE_BITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (s_axis_tdata),
        .i_eoi    (s_axis_tlast),
        .i_restart(s_axis_tuser),
        .o_result (w_result)
    );

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.warning, r_out.height, r_out.width, r_out.status};

endmodule
